// ----- src/i2sn_pkg.sv -----
package i2sn_pkg;

   localparam int WIDTH          = 32;
   localparam int ENTRY_BITS     = 6;
   localparam int VALUE_BITS     = WIDTH + 1;
   localparam int POS_BITS       = $clog2(WIDTH + 2);
   localparam int REQ_TDATA_BITS = ((WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((ENTRY_BITS + 7) / 8) * 8;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                         valid;
      logic signed [VALUE_BITS-1:0] value;
   } push_type;

endpackage

// ----- src/int_to_sparse_naf.sv -----
// Recodes a signed integer into non-adjacent form, one output word per
// nonzero digit, from the least significant position upward.
// The request channel takes one word per value in req_tdata. A zero value
// is accepted and produces no output words.
// Each output word carries the digit entry in rsp_tdata: the position p for
// a digit of +1, or -1-p for a digit of -1. rsp_tlast marks the most
// significant nonzero digit of the value.
// An accepted request is written into the queue, loaded into the recoder's
// value register once the recoder is idle, and then stepped over the zero
// digits below its lowest nonzero digit before its first output word is
// registered. Each recoder step covers two digit positions, or one where it
// passes a single zero just below a nonzero digit, so one value occupies the
// recoder for a loading step plus one step per pair or single zero passed.
// A two-word queue sits between the request side and the recoder, so new
// values are taken while a run is still being emitted.
// When the receiver stalls, the current output word holds and the recoder
// waits; requests are taken until the queue is full.
// Reset empties the queue and drops any run in progress.
module int_to_sparse_naf (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [i2sn_pkg::REQ_TDATA_BITS-1:0] req_tdata,  // value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [i2sn_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,  // entry
   output logic                                rsp_tlast
);

   i2sn_pkg::push_type                     push;
   logic                                   queue_full, pop_valid, pop;
   logic signed [i2sn_pkg::VALUE_BITS-1:0] pop_value;

   i2sn_front u_front (
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tready (req_tready),
      .queue_full (queue_full),
      .push       (push)
   );

   i2sn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_value (pop_value),
      .pop       (pop)
   );

   i2sn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_value  (pop_value),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tready (rsp_tready)
   );

endmodule

// ----- src/i2sn_front.sv -----
module i2sn_front (
   input  logic                                  req_tvalid,
   input  logic [i2sn_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   output logic                                  req_tready,
   input  logic                                  queue_full,
   output i2sn_pkg::push_type                    push
);

   logic nonzero;

   // A zero value has no nonzero digit, so it is accepted and dropped here.
   assign nonzero    = |req_tdata[i2sn_pkg::WIDTH-1:0];
   assign req_tready = !queue_full;

   always_comb begin
      push.valid = req_tvalid && !queue_full && nonzero;
      push.value = {req_tdata[i2sn_pkg::WIDTH-1], req_tdata[i2sn_pkg::WIDTH-1:0]};
   end

endmodule

// ----- src/i2sn_queue.sv -----
module i2sn_queue (
   input  logic                                      clock,
   input  logic                                      reset,
   input  i2sn_pkg::push_type                        push,
   output logic                                      full,
   output logic                                      pop_valid,
   output logic signed [i2sn_pkg::VALUE_BITS-1:0]    pop_value,
   input  logic                                      pop
);

   logic signed [i2sn_pkg::VALUE_BITS-1:0] store_ff [i2sn_pkg::QUEUE_DEPTH];
   logic [i2sn_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [i2sn_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [i2sn_pkg::QCNT_BITS-1:0] count_ff, count_in;
   logic                           do_push, do_pop;

   function automatic logic [i2sn_pkg::QPTR_BITS-1:0] next_ptr(
      input logic [i2sn_pkg::QPTR_BITS-1:0] ptr);
      if (ptr == i2sn_pkg::QPTR_BITS'(i2sn_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign full      = (count_ff == i2sn_pkg::QCNT_BITS'(i2sn_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_value = store_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.value;
      end
   end

endmodule

// ----- src/i2sn_back.sv -----
module i2sn_back (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      pop_valid,
   input  logic signed [i2sn_pkg::VALUE_BITS-1:0]    pop_value,
   output logic                                      pop,
   output logic                                      rsp_tvalid,
   output logic [i2sn_pkg::RSP_TDATA_BITS-1:0]       rsp_tdata,
   output logic                                      rsp_tlast,
   input  logic                                      rsp_tready
);

   logic signed [i2sn_pkg::VALUE_BITS-1:0] v_ff, v_in, v_adj, v_step;
   logic [i2sn_pkg::POS_BITS-1:0]          pos_ff, pos_in, pos_step;
   logic                                   busy_ff, busy_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [i2sn_pkg::ENTRY_BITS-1:0]        entry_ff, entry_in, pos_entry;
   logic                                   last_ff, last_in;
   logic                                   advance, odd, minus;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign pop     = !busy_ff && pop_valid;
   assign odd     = v_ff[0];
   assign minus   = v_ff[1];
   assign pos_entry = i2sn_pkg::ENTRY_BITS'(pos_ff);

   // A nonzero digit is always followed by a zero, so each step covers two
   // positions unless it skips a single zero.
   always_comb begin
      v_adj    = minus ? v_ff + 1'b1 : v_ff - 1'b1;
      v_step   = v_ff >>> 1;
      pos_step = pos_ff + 1'b1;
      if (odd) begin
         v_step   = v_adj >>> 2;
         pos_step = pos_ff + 2'd2;
      end else if (!v_ff[1]) begin
         v_step   = v_ff >>> 2;
         pos_step = pos_ff + 2'd2;
      end
   end

   always_comb begin
      v_in         = v_ff;
      pos_in       = pos_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      entry_in     = entry_ff;
      last_in      = last_ff;
      if (pop) begin
         v_in    = pop_value;
         pos_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff && advance) begin
         v_in    = v_step;
         pos_in  = pos_step;
         busy_in = (v_step != '0);
      end
      if (advance) begin
         rsp_valid_in = busy_ff && odd;
         entry_in     = minus ? ~pos_entry : pos_entry;
         last_in      = (v_step == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      pos_ff   <= pos_in;
      entry_ff <= entry_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = i2sn_pkg::RSP_TDATA_BITS'(entry_ff);
   assign rsp_tlast  = last_ff;

   a_busy_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (v_ff != '0))
      else $error("run in progress with nothing left to recode");

   a_inner_word_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_ff) |-> busy_ff)
      else $error("non-final word waiting after the run has ended");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff <= i2sn_pkg::POS_BITS'(i2sn_pkg::WIDTH - 1)))
      else $error("digit position beyond the top of the value");

endmodule
